// File: rtl/core/dtl_pkg.sv
// shared constants for the dynamic tree lca block
// operation codes and parameter defaults; no dependencies
package dtl_pkg;

    localparam int DEF_MAX_NODES  = 1024;
    localparam int DEF_LOG_LEVELS = 10;

    localparam int OP_W   = 2;
    localparam int NODE_W = 10;

    typedef enum logic [OP_W-1:0] {
        OP_ADD    = 2'd0,
        OP_REMOVE = 2'd1,
        OP_QUERY  = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

endpackage

// File: rtl/core/dynamic_tree_lca_with_deletion.sv
// dynamic tree with leaf add, node remove and nearest surviving lca query
// depends on dtl_pkg; depth, ancestor and set-link stores are internal memories
// sequence: add reads the parent, writes depth, set link and first ancestor, then fills
// the upper ancestor levels in turn; remove and query follow set links and ancestor levels
// throughput: one transaction at a time, start is taken only while busy is low
// reset: synchronous active low, clears the controller and sets the node counter to one
module dynamic_tree_lca_with_deletion
    import dtl_pkg::*;
#(
    parameter int MAX_NODES  = DEF_MAX_NODES,
    parameter int LOG_LEVELS = DEF_LOG_LEVELS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [OP_W-1:0]   i_operation,
    input  logic [NODE_W-1:0] i_node_a,
    input  logic [NODE_W-1:0] i_node_b,
    output logic              o_valid,
    output logic [NODE_W-1:0] o_answer_node
);

    localparam int LEVELS = LOG_LEVELS + 1;
    localparam int NW     = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int LW     = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int AW     = $clog2(MAX_NODES * LEVELS);
    localparam int CW     = 18;

    typedef enum logic [23:0] {
        S_IDLE    = 24'h000001,
        S_NORM    = 24'h000002,
        S_ADD_RD  = 24'h000004,
        S_ADD_WR  = 24'h000008,
        S_ADD_LRD = 24'h000010,
        S_ADD_LWR = 24'h000020,
        S_RM_RD   = 24'h000040,
        S_RM_P    = 24'h000080,
        S_RM_A    = 24'h000100,
        S_RM_WR   = 24'h000200,
        S_F_RD    = 24'h000400,
        S_F_CHK   = 24'h000800,
        S_Q_DU    = 24'h001000,
        S_Q_DV    = 24'h002000,
        S_Q_SW    = 24'h004000,
        S_Q_L1    = 24'h008000,
        S_Q_L1W   = 24'h010000,
        S_Q_EQ    = 24'h020000,
        S_Q_L2    = 24'h040000,
        S_Q_L2B   = 24'h080000,
        S_Q_L2C   = 24'h100000,
        S_Q_L3    = 24'h200000,
        S_Q_L3W   = 24'h400000,
        S_Q_OUT   = 24'h800000
    } t_state;

    logic [NW-1:0] m_depth [MAX_NODES];
    logic [NW-1:0] m_anc   [MAX_NODES*LEVELS];
    logic [NW-1:0] m_set   [MAX_NODES];

    t_state           r_state, n_state, r_ret, n_ret;
    logic [OP_W-1:0]  r_op, n_op;
    logic [NODE_W-1:0] r_raw_a, n_raw_a, r_raw_b, n_raw_b;
    logic [NW-1:0]    r_u, n_u, r_v, n_v, r_x, n_x, r_diff, n_diff, r_ru, n_ru;
    logic [LW-1:0]    r_i, n_i;
    logic [NW:0]      r_next, n_next;

    logic [NW-1:0]    rd_node;
    logic [LW-1:0]    rd_lvl;
    logic [AW-1:0]    rd_addr;
    logic             r_rz;
    logic [NW-1:0]    r_dep_q, r_anc_q, r_set_q;
    logic [NW-1:0]    dep_d, anc_d, set_d;

    logic             we_dep, we_anc, we_set;
    logic [NW-1:0]    wa_dep, wa_set, wd_dep, wd_anc, wd_set;
    logic [AW-1:0]    wa_anc;

    logic [NW-1:0]    child;
    logic [CW-1:0]    step;

    assign child   = r_next[NW-1:0];
    assign rd_addr = AW'(rd_node) * AW'(LEVELS) + AW'(rd_lvl);
    assign dep_d   = r_rz ? '0 : r_dep_q;
    assign anc_d   = r_rz ? '0 : r_anc_q;
    assign set_d   = r_rz ? '0 : r_set_q;
    assign step    = CW'(1) << r_i;

    assign busy          = (r_state != S_IDLE);
    assign o_valid       = (r_state == S_Q_OUT);
    assign o_answer_node = NODE_W'(r_x);

    always_ff @(posedge i_clk) begin
        r_dep_q <= m_depth[rd_node];
        r_anc_q <= m_anc[rd_addr];
        r_set_q <= m_set[rd_node];
        r_rz    <= (rd_node == '0);
        if (we_dep) begin
            m_depth[wa_dep] <= wd_dep;
        end
        if (we_anc) begin
            m_anc[wa_anc] <= wd_anc;
        end
        if (we_set) begin
            m_set[wa_set] <= wd_set;
        end
    end

    always_comb begin
        n_state = r_state;
        n_ret   = r_ret;
        n_op    = r_op;
        n_raw_a = r_raw_a;
        n_raw_b = r_raw_b;
        n_u     = r_u;
        n_v     = r_v;
        n_x     = r_x;
        n_diff  = r_diff;
        n_ru    = r_ru;
        n_i     = r_i;
        n_next  = r_next;
        rd_node = r_u;
        rd_lvl  = '0;
        we_dep  = 1'b0;
        we_anc  = 1'b0;
        we_set  = 1'b0;
        wa_dep  = child;
        wa_set  = child;
        wa_anc  = AW'(child) * AW'(LEVELS);
        wd_dep  = dep_d + NW'(1);
        wd_anc  = r_u;
        wd_set  = child;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_op    = i_operation;
                    n_raw_a = i_node_a;
                    n_raw_b = i_node_b;
                    n_state = S_NORM;
                end
            end
            S_NORM: begin
                if (CW'(r_raw_a) >= CW'(MAX_NODES)) begin
                    n_raw_a = r_raw_a - NODE_W'(MAX_NODES);
                end else if (CW'(r_raw_b) >= CW'(MAX_NODES)) begin
                    n_raw_b = r_raw_b - NODE_W'(MAX_NODES);
                end else begin
                    n_u = NW'(r_raw_a);
                    n_v = NW'(r_raw_b);
                    case (t_op'(r_op))
                        OP_ADD: begin
                            n_state = (r_next == (NW+1)'(MAX_NODES)) ? S_IDLE : S_ADD_RD;
                        end
                        OP_REMOVE: n_state = S_RM_RD;
                        OP_QUERY:  n_state = S_Q_DU;
                        default:   n_state = S_IDLE;
                    endcase
                end
            end
            S_ADD_RD: begin
                rd_node = r_u;
                n_state = S_ADD_WR;
            end
            S_ADD_WR: begin
                we_dep  = 1'b1;
                we_set  = 1'b1;
                we_anc  = 1'b1;
                n_x     = r_u;
                n_i     = LW'(1);
                n_state = S_ADD_LRD;
            end
            S_ADD_LRD: begin
                rd_node = r_x;
                rd_lvl  = r_i - LW'(1);
                n_state = S_ADD_LWR;
            end
            S_ADD_LWR: begin
                we_anc = 1'b1;
                wa_anc = AW'(child) * AW'(LEVELS) + AW'(r_i);
                wd_anc = anc_d;
                n_x    = anc_d;
                if (r_i == LW'(LOG_LEVELS)) begin
                    n_next  = r_next + (NW+1)'(1);
                    n_state = S_IDLE;
                end else begin
                    n_i     = r_i + LW'(1);
                    n_state = S_ADD_LRD;
                end
            end
            S_RM_RD: begin
                rd_node = r_u;
                n_state = S_RM_P;
            end
            S_RM_P: begin
                n_v     = anc_d;
                n_x     = r_u;
                n_ret   = S_RM_A;
                n_state = S_F_RD;
            end
            S_RM_A: begin
                n_v     = r_x;
                n_x     = r_v;
                n_ret   = S_RM_WR;
                n_state = S_F_RD;
            end
            S_RM_WR: begin
                if (r_v != r_x) begin
                    we_set = 1'b1;
                    wa_set = r_v;
                    wd_set = r_x;
                end
                n_state = S_IDLE;
            end
            S_F_RD: begin
                rd_node = r_x;
                n_state = S_F_CHK;
            end
            S_F_CHK: begin
                if (set_d == r_x) begin
                    n_state = r_ret;
                end else begin
                    n_x     = set_d;
                    n_state = S_F_RD;
                end
            end
            S_Q_DU: begin
                rd_node = r_u;
                n_state = S_Q_DV;
            end
            S_Q_DV: begin
                rd_node = r_v;
                n_diff  = dep_d;
                n_state = S_Q_SW;
            end
            S_Q_SW: begin
                if (dep_d > r_diff) begin
                    n_u    = r_v;
                    n_v    = r_u;
                    n_diff = dep_d - r_diff;
                end else begin
                    n_diff = r_diff - dep_d;
                end
                n_i     = LW'(LOG_LEVELS);
                n_state = S_Q_L1;
            end
            S_Q_L1: begin
                rd_node = r_u;
                rd_lvl  = r_i;
                if (CW'(r_diff) >= step) begin
                    n_state = S_Q_L1W;
                end else if (r_i == '0) begin
                    n_state = S_Q_EQ;
                end else begin
                    n_i = r_i - LW'(1);
                end
            end
            S_Q_L1W: begin
                n_u    = anc_d;
                n_diff = r_diff - NW'(step);
                if (r_i == '0) begin
                    n_state = S_Q_EQ;
                end else begin
                    n_i     = r_i - LW'(1);
                    n_state = S_Q_L1;
                end
            end
            S_Q_EQ: begin
                n_i = LW'(LOG_LEVELS);
                if (r_u == r_v) begin
                    n_x     = r_u;
                    n_ret   = S_Q_OUT;
                    n_state = S_F_RD;
                end else begin
                    n_state = S_Q_L2;
                end
            end
            S_Q_L2: begin
                rd_node = r_u;
                rd_lvl  = r_i;
                n_state = S_Q_L2B;
            end
            S_Q_L2B: begin
                rd_node = r_v;
                rd_lvl  = r_i;
                n_ru    = anc_d;
                n_state = S_Q_L2C;
            end
            S_Q_L2C: begin
                if (r_ru != anc_d) begin
                    n_u = r_ru;
                    n_v = anc_d;
                end
                if (r_i == '0) begin
                    n_state = S_Q_L3;
                end else begin
                    n_i     = r_i - LW'(1);
                    n_state = S_Q_L2;
                end
            end
            S_Q_L3: begin
                rd_node = r_u;
                n_state = S_Q_L3W;
            end
            S_Q_L3W: begin
                n_x     = anc_d;
                n_ret   = S_Q_OUT;
                n_state = S_F_RD;
            end
            S_Q_OUT: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ret   <= S_IDLE;
            r_next  <= (NW+1)'(1);
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
            r_next  <= n_next;
        end
        r_op    <= n_op;
        r_raw_a <= n_raw_a;
        r_raw_b <= n_raw_b;
        r_u     <= n_u;
        r_v     <= n_v;
        r_x     <= n_x;
        r_diff  <= n_diff;
        r_ru    <= n_ru;
        r_i     <= n_i;
    end

endmodule

// File: rtl/core/dtl_checker.sv
// port-level checks for the dynamic tree lca block, bound to its top level
// depends on dtl_pkg for operation codes
module dtl_checker
    import dtl_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              start,
    input logic              busy,
    input logic [OP_W-1:0]   i_operation,
    input logic              o_valid
);

    a_valid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> busy) else $error("result outside a transaction");

    a_valid_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid) else $error("result strobe longer than one cycle");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy) else $error("accepted transaction not busy");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !busy) else $error("still busy after result");

    a_no_early: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_operation != OP_QUERY)) |=> !o_valid)
        else $error("result too early");

endmodule

bind dynamic_tree_lca_with_deletion dtl_checker u_dtl_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .i_operation (i_operation),
    .o_valid     (o_valid)
);
